FILE: rtl/bgas_pkg.sv
// Shared types and constants of the binary grid automaton smoother.
// Holds command codes, sequencer states and register map; no dependencies.
package bgas_pkg;

  // Grid limits used as parameter defaults
  localparam int unsigned MaxWidthDef  = 64;
  localparam int unsigned MaxHeightDef = 64;

  // Register map, word index
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FIRST_PASS  = 3'd2;
  localparam logic [2:0] REG_SECOND_PASS = 3'd3;
  localparam logic [2:0] REG_NEAR_THR    = 3'd4;
  localparam logic [2:0] REG_FAR_THR     = 3'd5;

  // Register reset values
  localparam logic [6:0] GridWidthRst  = 7'd64;
  localparam logic [6:0] GridHeightRst = 7'd64;
  localparam logic [3:0] FirstPassRst  = 4'd5;
  localparam logic [3:0] SecondPassRst = 4'd10;
  localparam logic [3:0] NearThrRst    = 4'd5;
  localparam logic [4:0] FarThrRst     = 5'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_CELL,
    ST_TAP_LAST,
    ST_CELL_WR,
    ST_COPY,
    ST_COPY_LAST,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/binary_grid_automaton_smoother.sv
// Binary grid automaton smoother: grid store, APB registers and pass sequencer.
// Depends on bgas_pkg.
//
// A cell write or an out-of-grid access registers its result transfer, which is
// offered on the next cycle; a cell read passes through a wait state for the
// registered read of the grid memory. A run makes P = first_pass_count +
// second_pass_count passes over a W x H grid: every cell visits its 25 window
// taps one per cycle through the single read port of the grid memory, then a
// drain state and a write state, and each pass ends with a copy sweep of one
// cell a cycle from the result memory back into the grid. The block takes no
// new item while a command is at work.
// The memories need no clearing after reset.
module binary_grid_automaton_smoother #(
  parameter int unsigned MAX_WIDTH  = bgas_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = bgas_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], column[7:2], row[13:8], write_value[14], zero[15]
  input  logic [15:0] s_axis_tdata,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // command_echo[1:0], read_value[2], out_of_range[3], zero[7:4]
  output logic [7:0]  m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bgas_pkg::*;

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DW    = ((XW > YW) ? XW : YW) + 2;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  // ---------------------------------------------------------------- registers
  logic [6:0] grid_width_q, grid_height_q;
  logic [3:0] first_pass_q, second_pass_q, near_thr_q;
  logic [4:0] far_thr_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridWidthRst;
      grid_height_q <= GridHeightRst;
      first_pass_q  <= FirstPassRst;
      second_pass_q <= SecondPassRst;
      near_thr_q    <= NearThrRst;
      far_thr_q     <= FarThrRst;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[6:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[6:0];
        REG_FIRST_PASS:  first_pass_q  <= pwdata[3:0];
        REG_SECOND_PASS: second_pass_q <= pwdata[3:0];
        REG_NEAR_THR:    near_thr_q    <= pwdata[3:0];
        REG_FAR_THR:     far_thr_q     <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GRID_WIDTH:  prdata = {25'd0, grid_width_q};
      REG_GRID_HEIGHT: prdata = {25'd0, grid_height_q};
      REG_FIRST_PASS:  prdata = {28'd0, first_pass_q};
      REG_SECOND_PASS: prdata = {28'd0, second_pass_q};
      REG_NEAR_THR:    prdata = {28'd0, near_thr_q};
      REG_FAR_THR:     prdata = {27'd0, far_thr_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Effective grid size, zero counts as one, clamped to the maximum
  logic [31:0] w_int, h_int;
  always_comb begin
    if (grid_width_q == 7'd0) w_int = 32'd1;
    else if (32'(grid_width_q) > MAX_WIDTH) w_int = MAX_WIDTH;
    else w_int = 32'(grid_width_q);
    if (grid_height_q == 7'd0) h_int = 32'd1;
    else if (32'(grid_height_q) > MAX_HEIGHT) h_int = MAX_HEIGHT;
    else h_int = 32'(grid_height_q);
  end

  // ---------------------------------------------------------------- memories
  logic          cur_mem [CELLS];
  logic          nxt_mem [CELLS];
  logic [AW-1:0] cur_raddr, cur_waddr, cell_addr;
  logic          cur_we, cur_wdata, cur_rdata_q;
  logic          nxt_we, nxt_wdata, nxt_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_rdata_q <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[cell_addr] <= nxt_wdata;
    nxt_rdata_q <= nxt_mem[cell_addr];
  end

  // ---------------------------------------------------------------- sequencer
  state_e               state_q, state_d;
  logic [XW-1:0]        x_q, x_d;
  logic [YW-1:0]        y_q, y_d;
  logic signed [2:0]    tdx_q, tdx_d, tdy_q, tdy_d;
  logic [3:0]           near_q, near_d;
  logic [4:0]           far_q, far_d;
  logic                 tap_vld_q, tap_vld_d, tap_near_q, tap_near_d;
  logic                 cp_vld_q, cp_vld_d;
  logic [AW-1:0]        cp_addr_q;
  logic [3:0]           left_q, left_d;
  logic                 phase_a_q, phase_a_d;
  logic                 m_vld_q, m_vld_d, m_rd_q, m_rd_d, m_oor_q, m_oor_d;
  cmd_e                 m_cmd_q, m_cmd_d;

  cmd_e                 in_cmd;
  logic [5:0]           in_col, in_row;
  logic                 in_wv, in_acc, in_range;
  logic [AW-1:0]        host_addr;
  logic signed [DW-1:0] nx, ny, w_s, h_s;
  logic                 tap_in, tap_last, last_x, last_y, room;
  logic [AW-1:0]        tap_addr;

  assign in_cmd   = cmd_e'(s_axis_tdata[1:0]);
  assign in_col   = s_axis_tdata[7:2];
  assign in_row   = s_axis_tdata[13:8];
  assign in_wv    = s_axis_tdata[14];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign in_range = (32'(in_col) < w_int) && (32'(in_row) < h_int);
  assign host_addr = AW'(32'(in_row) * MAX_WIDTH + 32'(in_col));

  // Window tap position and its bounds test
  assign w_s = DW'(w_int);
  assign h_s = DW'(h_int);
  assign nx  = $signed({{(DW-XW){1'b0}}, x_q}) + $signed({{(DW-3){tdx_q[2]}}, tdx_q});
  assign ny  = $signed({{(DW-YW){1'b0}}, y_q}) + $signed({{(DW-3){tdy_q[2]}}, tdy_q});
  assign tap_in = (nx >= 0) && (nx < w_s) && (ny >= 0) && (ny < h_s)
                  && !((tdx_q == 3'sd0) && (tdy_q == 3'sd0));
  assign tap_addr  = AW'(int'(ny) * int'(MAX_WIDTH) + int'(nx));
  assign tap_last  = (tdx_q == 3'sd2) && (tdy_q == 3'sd2);
  assign cell_addr = AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
  assign last_x    = (32'(x_q) == w_int - 32'd1);
  assign last_y    = (32'(y_q) == h_int - 32'd1);
  assign room      = (near_q >= near_thr_q) || (phase_a_q && (far_q <= far_thr_q));

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_vld_q || m_axis_tready);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {4'd0, m_oor_q, m_rd_q, m_cmd_q};

  // Memory port control
  always_comb begin
    cur_raddr = (state_q == ST_IDLE) ? host_addr : tap_addr;
    cur_we    = (in_acc && in_cmd == CMD_WRITE && in_range) || cp_vld_q;
    cur_waddr = cp_vld_q ? cp_addr_q : host_addr;
    cur_wdata = cp_vld_q ? nxt_rdata_q : in_wv;
    nxt_we    = (state_q == ST_CELL_WR);
    nxt_wdata = !room;
  end

  // Next state and datapath
  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    tdx_d      = tdx_q;
    tdy_d      = tdy_q;
    near_d     = near_q;
    far_d      = far_q;
    tap_vld_d  = 1'b0;
    tap_near_d = 1'b0;
    cp_vld_d   = 1'b0;
    left_d     = left_q;
    phase_a_d  = phase_a_q;
    m_vld_d    = m_vld_q & ~m_axis_tready;
    m_cmd_d    = m_cmd_q;
    m_rd_d     = m_rd_q;
    m_oor_d    = m_oor_q;

    // accumulate the tap issued in the previous cycle
    if (tap_vld_q && cur_rdata_q) begin
      far_d = far_q + 5'd1;
      if (tap_near_q) near_d = near_q + 4'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_RUN) begin
            x_d    = '0;
            y_d    = '0;
            tdx_d  = -3'sd2;
            tdy_d  = -3'sd2;
            near_d = '0;
            far_d  = '0;
            if (first_pass_q != 4'd0) begin
              phase_a_d = 1'b1;
              left_d    = first_pass_q;
              state_d   = ST_CELL;
            end else if (second_pass_q != 4'd0) begin
              phase_a_d = 1'b0;
              left_d    = second_pass_q;
              state_d   = ST_CELL;
            end else begin
              state_d = ST_DONE;
            end
          end else if (in_cmd == CMD_READ && in_range) begin
            state_d = ST_RD_WAIT;
          end else begin
            m_vld_d = 1'b1;
            m_cmd_d = in_cmd;
            m_rd_d  = 1'b0;
            m_oor_d = (in_cmd == CMD_WRITE || in_cmd == CMD_READ) && !in_range;
          end
        end
      end
      ST_RD_WAIT: begin
        m_vld_d = 1'b1;
        m_cmd_d = CMD_READ;
        m_rd_d  = cur_rdata_q;
        m_oor_d = 1'b0;
        state_d = ST_IDLE;
      end
      ST_CELL: begin
        tap_vld_d  = tap_in;
        tap_near_d = (tdx_q >= -3'sd1) && (tdx_q <= 3'sd1)
                     && (tdy_q >= -3'sd1) && (tdy_q <= 3'sd1);
        if (tap_last) begin
          state_d = ST_TAP_LAST;
        end else if (tdx_q == 3'sd2) begin
          tdx_d = -3'sd2;
          tdy_d = tdy_q + 3'sd1;
        end else begin
          tdx_d = tdx_q + 3'sd1;
        end
      end
      ST_TAP_LAST: begin
        state_d = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        tdx_d  = -3'sd2;
        tdy_d  = -3'sd2;
        near_d = '0;
        far_d  = '0;
        state_d = ST_CELL;
        if (last_x) begin
          x_d = '0;
          if (last_y) begin
            y_d     = '0;
            state_d = ST_COPY;
          end else begin
            y_d = y_q + 1'b1;
          end
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      ST_COPY: begin
        cp_vld_d = 1'b1;
        if (last_x) begin
          x_d = '0;
          if (last_y) begin
            y_d     = '0;
            state_d = ST_COPY_LAST;
          end else begin
            y_d = y_q + 1'b1;
          end
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      ST_COPY_LAST: begin
        near_d = '0;
        far_d  = '0;
        tdx_d  = -3'sd2;
        tdy_d  = -3'sd2;
        if (left_q > 4'd1) begin
          left_d  = left_q - 4'd1;
          state_d = ST_CELL;
        end else if (phase_a_q && second_pass_q != 4'd0) begin
          phase_a_d = 1'b0;
          left_d    = second_pass_q;
          state_d   = ST_CELL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        m_vld_d = 1'b1;
        m_cmd_d = CMD_RUN;
        m_rd_d  = 1'b0;
        m_oor_d = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_vld_q <= 1'b0;
      cp_vld_q  <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_vld_q <= tap_vld_d;
      cp_vld_q  <= cp_vld_d;
      m_vld_q   <= m_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    tdx_q      <= tdx_d;
    tdy_q      <= tdy_d;
    near_q     <= near_d;
    far_q      <= far_d;
    tap_near_q <= tap_near_d;
    cp_addr_q  <= cell_addr;
    left_q     <= left_d;
    phase_a_q  <= phase_a_d;
    m_cmd_q    <= m_cmd_d;
    m_rd_q     <= m_rd_d;
    m_oor_q    <= m_oor_d;
  end

  // ---------------------------------------------------------------- checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE)
    else $error("ready outside idle");

  a_near_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CELL_WR |-> (5'(near_q) <= far_q) && (near_q <= 4'd8))
    else $error("near count exceeds window");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE || state_q == ST_RD_WAIT) |-> !m_vld_q)
    else $error("result register busy when loading");

  a_copy_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_vld_q |-> (state_q == ST_COPY || state_q == ST_COPY_LAST))
    else $error("copy write outside sweep");

endmodule
